[rtl/core/tlv_pkg.sv]
// tlv frame receiver package: codes, widths and reset values
package tlv_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned CSR_AW   = 3;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] REC_ID_CONFIG      = 8'h01;
   localparam logic [BYTE_W-1:0] REC_ID_ACK         = 8'h02;
   localparam logic [VALUE_W-1:0] VALUE_ZERO        = 16'h0000;
   localparam logic [VALUE_W-1:0] VALUE_ONE         = 16'h0001;

   // register index taken from the word address bit
   localparam logic REG_START_MARKER = 1'b0;

   typedef enum logic [3:0] {
      PH_WAIT = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_PAY  = 4'b0100,
      PH_SUM  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      RP_ID  = 3'b001,
      RP_LEN = 3'b010,
      RP_VAL = 3'b100
   } rec_phase_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE   = 2'd0,
      ACT_CONFIG = 2'd1,
      ACT_NACK   = 2'd2,
      ACT_ACK    = 2'd3
   } action_type;

endpackage

[rtl/core/tlv_req_if.sv]
// byte channel into the frame receiver
interface tlv_req_if
   import tlv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/tlv_rsp_if.sv]
// frame result channel out of the frame receiver
interface tlv_rsp_if
   import tlv_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                frame_good;
   logic [BYTE_W-1:0]   record_id;
   logic [VALUE_W-1:0]  record_value;
   logic [ACTION_W-1:0] action;
   logic                ack_seen;
   logic [COUNT_W-1:0]  ack_total;

   modport source (output valid, output frame_good, output record_id, output record_value,
                   output action, output ack_seen, output ack_total, input ready);
   modport sink   (input valid, input frame_good, input record_id, input record_value,
                   input action, input ack_seen, input ack_total, output ready);
endinterface

[rtl/core/tlv_frame_receiver.sv]
// tlv frame receiver: start, length, payload records, checksum parser
//
//  channel  dir  handshake      payload
//  req_bus  in   valid/ready    rx_byte
//  rsp_bus  out  valid/ready    frame_good, record_id, record_value, action, ack_seen, ack_total
//  csr_*    in   apb, pready=1  start_marker at byte address 0
//
//  one byte per cycle while no checksum byte is held: a byte is captured in the input register,
//  then the parser state and the result register update from it when it advances
//  only the checksum byte makes a result; it waits for the result register to drain
//  ready drops only while a checksum byte is held behind an untaken result
//  synchronous reset clears the parser, the ack flag and counter, and the marker to 0xAA
module tlv_frame_receiver
   import tlv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tlv_req_if.sink           req_bus,
   tlv_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [BYTE_W-1:0]   start_marker_ff;
   logic                in_valid_ff;
   logic [BYTE_W-1:0]   in_byte_ff;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0]   byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0]   running_sum_ff, running_sum_in;
   rec_phase_type       rec_phase_ff, rec_phase_in;
   logic [BYTE_W-1:0]   current_id_ff, current_id_in;
   logic [BYTE_W-1:0]   bytes_left_ff, bytes_left_in;
   logic                value_wide_ff, value_wide_in;
   logic [VALUE_W-1:0]  current_value_ff, current_value_in;
   logic                ack_flag_ff, ack_flag_in;
   logic [COUNT_W-1:0]  ack_count_ff, ack_count_in;

   logic                out_valid_ff;
   logic                out_good_ff;
   logic [BYTE_W-1:0]   out_id_ff;
   logic [VALUE_W-1:0]  out_value_ff;
   action_type          out_action_ff;
   logic                out_ack_seen_ff;
   logic [COUNT_W-1:0]  out_ack_total_ff;

   logic                is_result;
   logic                advance;
   logic                good;
   action_type          act;
   logic [BYTE_W-1:0]   b;
   logic [BYTE_W:0]     index_next;
   logic [BYTE_W-1:0]   left_dec;
   logic                csr_write;

   assign b          = in_byte_ff;
   assign is_result  = (phase_ff == PH_SUM);
   assign advance    = in_valid_ff && (!is_result || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign index_next = {1'b0, byte_index_ff} + {{BYTE_W{1'b0}}, 1'b1};
   assign left_dec   = bytes_left_ff - 8'd1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_START_MARKER)
                       ? {{(CSR_DW-BYTE_W){1'b0}}, start_marker_ff} : '0;

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      byte_index_in    = byte_index_ff;
      running_sum_in   = running_sum_ff;
      rec_phase_in     = rec_phase_ff;
      current_id_in    = current_id_ff;
      bytes_left_in    = bytes_left_ff;
      value_wide_in    = value_wide_ff;
      current_value_in = current_value_ff;
      ack_flag_in      = ack_flag_ff;
      ack_count_in     = ack_count_ff;
      good             = (b == running_sum_ff);
      act              = ACT_NONE;
      case (phase_ff)
         PH_LEN: begin
            frame_length_in  = b;
            byte_index_in    = '0;
            running_sum_in   = '0;
            rec_phase_in     = RP_ID;
            current_id_in    = '0;
            current_value_in = '0;
            bytes_left_in    = '0;
            value_wide_in    = 1'b0;
            phase_in         = (b == 8'd0) ? PH_SUM : PH_PAY;
         end
         PH_PAY: begin
            running_sum_in = running_sum_ff + b;
            case (rec_phase_ff)
               RP_LEN: begin
                  bytes_left_in = b;
                  value_wide_in = (b > 8'd1);
                  rec_phase_in  = (b == 8'd0) ? RP_ID : RP_VAL;
               end
               RP_VAL: begin
                  if (value_wide_ff) begin
                     current_value_in = {b, 8'h00};
                     value_wide_in    = 1'b0;
                  end else begin
                     current_value_in = current_value_ff + {8'h00, b};
                  end
                  bytes_left_in = left_dec;
                  if (left_dec == 8'd0) rec_phase_in = RP_ID;
               end
               default: begin
                  current_id_in    = b;
                  current_value_in = '0;
                  value_wide_in    = 1'b0;
                  bytes_left_in    = '0;
                  rec_phase_in     = RP_LEN;
               end
            endcase
            if (index_next >= {1'b0, frame_length_ff}) begin
               byte_index_in = '0;
               phase_in      = PH_SUM;
            end else begin
               byte_index_in = index_next[BYTE_W-1:0];
            end
         end
         PH_SUM: begin
            if (good) begin
               if (current_id_ff == REC_ID_CONFIG && current_value_ff == VALUE_ONE) begin
                  act = ACT_CONFIG;
               end else if (current_id_ff == REC_ID_ACK && current_value_ff == VALUE_ZERO) begin
                  act         = ACT_NACK;
                  ack_flag_in = 1'b0;
               end else if (current_id_ff == REC_ID_ACK && current_value_ff == VALUE_ONE) begin
                  act          = ACT_ACK;
                  ack_flag_in  = 1'b1;
                  ack_count_in = ack_count_ff + 16'd1;
               end
            end
            phase_in = PH_WAIT;
         end
         default: begin
            running_sum_in = '0;
            if (b == start_marker_ff) phase_in = PH_LEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= PH_WAIT;
         frame_length_ff <= '0;
         byte_index_ff   <= '0;
         running_sum_ff  <= '0;
         rec_phase_ff    <= RP_ID;
         current_id_ff   <= '0;
         bytes_left_ff   <= '0;
         value_wide_ff   <= 1'b0;
         current_value_ff <= '0;
         ack_flag_ff     <= 1'b0;
         ack_count_ff    <= '0;
      end else begin
         if (csr_write && csr_paddr[2] == REG_START_MARKER) begin
            start_marker_ff <= csr_pwdata[BYTE_W-1:0];
         end
         if (req_bus.ready) in_valid_ff <= req_bus.valid;
         if (advance) begin
            phase_ff         <= phase_in;
            frame_length_ff  <= frame_length_in;
            byte_index_ff    <= byte_index_in;
            running_sum_ff   <= running_sum_in;
            rec_phase_ff     <= rec_phase_in;
            current_id_ff    <= current_id_in;
            bytes_left_ff    <= bytes_left_in;
            value_wide_ff    <= value_wide_in;
            current_value_ff <= current_value_in;
            ack_flag_ff      <= ack_flag_in;
            ack_count_ff     <= ack_count_in;
         end
         if (advance && is_result) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) in_byte_ff <= req_bus.rx_byte;
      if (advance && is_result) begin
         out_good_ff      <= good;
         out_id_ff        <= current_id_ff;
         out_value_ff     <= current_value_ff;
         out_action_ff    <= act;
         out_ack_seen_ff  <= ack_flag_in;
         out_ack_total_ff <= ack_count_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.frame_good   = out_good_ff;
   assign rsp_bus.record_id    = out_id_ff;
   assign rsp_bus.record_value = out_value_ff;
   assign rsp_bus.action       = out_action_ff;
   assign rsp_bus.ack_seen     = out_ack_seen_ff;
   assign rsp_bus.ack_total    = out_ack_total_ff;

   a_result_from_checksum: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(out_valid_ff) |-> $past(advance && phase_ff == PH_SUM))
      else $error("result appeared without a checksum byte");

   a_ack_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && ack_count_ff != $past(ack_count_ff)
      |-> ack_flag_ff && ack_count_ff == $past(ack_count_ff) + 16'd1)
      else $error("ack counter moved without an ack");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAY |-> byte_index_ff < frame_length_ff)
      else $error("payload index past frame length");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input word lost");

   a_action_needs_good: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_action_ff != ACT_NONE |-> out_good_ff)
      else $error("action reported on a bad frame");

endmodule

[tb/tlv_frame_receiver_tb.sv]
// testbench for tlv_frame_receiver: directed and random byte streams checked by a frame parser model
module tlv_frame_receiver_tb
   import tlv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned HOLD_OFF_CYCLES = 120;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned PHASE_BYTES     = 80;
   localparam int unsigned N_PHASES        = 5;

   localparam logic [CSR_AW-1:0] CSR_ADDR_MARKER = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] CSR_ADDR_SPARE  = CSR_AW'(4);

   typedef struct packed {
      logic                frame_good;
      logic [BYTE_W-1:0]   record_id;
      logic [VALUE_W-1:0]  record_value;
      action_type          action;
      logic                ack_seen;
      logic [COUNT_W-1:0]  ack_total;
   } frame_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      frame_result_type  want;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;
   localparam int unsigned N_ROWS = 25;

   // noise, zero length bad and good, ack, nack, config request
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, '{1'b0, 8'h00, 16'h0000, ACT_NONE, 1'b0, 16'h0000}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{1'b1, 8'h00, 16'h0000, ACT_NONE, 1'b0, 16'h0000}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h04, 1'b1, '{1'b1, 8'h02, 16'h0001, ACT_ACK, 1'b1, 16'h0001}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h03, 1'b1, '{1'b1, 8'h02, 16'h0000, ACT_NACK, 1'b0, 16'h0001}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'h03, 1'b1, '{1'b1, 8'h01, 16'h0001, ACT_CONFIG, 1'b0, 16'h0001}}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   tlv_req_if req_if ();
   tlv_rsp_if rsp_if ();

   tlv_frame_receiver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // parser model state
   logic [BYTE_W-1:0]  pp_marker;
   phase_type          pp_phase;
   logic [BYTE_W-1:0]  pp_len;
   logic [BYTE_W-1:0]  pp_index;
   logic [BYTE_W-1:0]  pp_sum;
   rec_phase_type      pp_rec;
   logic [BYTE_W-1:0]  pp_id;
   logic [BYTE_W-1:0]  pp_left;
   logic               pp_wide;
   logic [VALUE_W-1:0] pp_value;
   logic               pp_ack;
   logic [COUNT_W-1:0] pp_acks;

   frame_result_type frames_due[$];
   int unsigned   errors         = 0;
   int unsigned   cycles         = 0;
   int unsigned   bytes_accepted = 0;
   int unsigned   bytes_used     = 0;
   int unsigned   frames_checked = 0;
   int unsigned   frames_good    = 0;
   int unsigned   actions_seen   = 0;
   int unsigned   big_frames     = 0;
   bit            no_idle        = 1'b0;
   bit            hold_off_req   = 1'b0;

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic bit frame_parse_byte(input logic [BYTE_W-1:0] b,
                                           output frame_result_type res);
      res = NO_RESULT;
      case (pp_phase)
         PH_WAIT: begin
            pp_sum = '0;
            if (b == pp_marker)
               pp_phase = PH_LEN;
            return 1'b0;
         end
         PH_LEN: begin
            pp_len   = b;
            pp_index = '0;
            pp_sum   = '0;
            pp_rec   = RP_ID;
            pp_id    = '0;
            pp_value = '0;
            pp_left  = '0;
            pp_wide  = 1'b0;
            pp_phase = (b == 8'd0) ? PH_SUM : PH_PAY;
            return 1'b0;
         end
         PH_PAY: begin
            pp_sum = pp_sum + b;
            case (pp_rec)
               RP_LEN: begin
                  pp_left = b;
                  pp_wide = (b > 8'd1);
                  pp_rec  = (b == 8'd0) ? RP_ID : RP_VAL;
               end
               RP_VAL: begin
                  if (pp_wide) begin
                     pp_value = {b, 8'h00};
                     pp_wide  = 1'b0;
                  end else begin
                     pp_value = pp_value + {8'h00, b};
                  end
                  pp_left = pp_left - 8'd1;
                  if (pp_left == 8'd0)
                     pp_rec = RP_ID;
               end
               default: begin
                  pp_id    = b;
                  pp_value = '0;
                  pp_wide  = 1'b0;
                  pp_left  = '0;
                  pp_rec   = RP_LEN;
               end
            endcase
            if ({1'b0, pp_index} + 9'd1 >= {1'b0, pp_len}) begin
               pp_index = '0;
               pp_phase = PH_SUM;
            end else begin
               pp_index = pp_index + 8'd1;
            end
            return 1'b0;
         end
         default: begin
            res.frame_good = (b == pp_sum);
            res.action     = ACT_NONE;
            if (res.frame_good) begin
               if (pp_id == REC_ID_CONFIG && pp_value == VALUE_ONE) begin
                  res.action = ACT_CONFIG;
               end else if (pp_id == REC_ID_ACK && pp_value == VALUE_ZERO) begin
                  res.action = ACT_NACK;
                  pp_ack     = 1'b0;
               end else if (pp_id == REC_ID_ACK && pp_value == VALUE_ONE) begin
                  res.action = ACT_ACK;
                  pp_ack     = 1'b1;
                  pp_acks    = pp_acks + 16'd1;
               end
            end
            pp_phase           = PH_WAIT;
            res.record_id      = pp_id;
            res.record_value   = pp_value;
            res.ack_seen       = pp_ack;
            res.ack_total      = pp_acks;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input frame_result_type want = NO_RESULT);
      int unsigned      gap;
      frame_result_type got;
      bit               due;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      if (pp_phase != PH_WAIT || b == pp_marker)
         bytes_used++;
      due = frame_parse_byte(b, got);
      if (due)
         frames_due.push_back(typed ? want : got);
      bytes_accepted++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] marker);
      logic [BYTE_W-1:0] body[$];
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] rlen;
      int unsigned       kind;
      int unsigned       k;
      int unsigned       n_sent;
      bit                broken;
      kind = $urandom_range(0, 99);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      if (big_frames < 2 && kind < 3) begin
         len = (big_frames == 0) ? 8'd255 : 8'($urandom_range(128, 254));
         big_frames++;
      end else begin
         len = 8'($urandom_range(0, 12));
      end
      if (kind >= 3 && kind < 12) begin
         while (body.size() < len)
            body.push_back(8'($urandom));
      end else begin
         while (body.size() < len) begin
            k    = $urandom_range(0, 9);
            id   = (k < 4) ? REC_ID_ACK : (k < 6) ? REC_ID_CONFIG : 8'($urandom);
            k    = $urandom_range(0, 9);
            rlen = (k < 5) ? 8'd1 : (k < 7) ? 8'd2 : (k < 8) ? 8'd0 : 8'($urandom_range(3, 6));
            body.push_back(id);
            body.push_back(rlen);
            for (int j = 0; j < rlen; j++)
               body.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 1)));
         end
         while (body.size() > len)
            void'(body.pop_back());
      end
      sum = '0;
      foreach (body[j])
         sum = sum + body[j];
      if ($urandom_range(0, 9) == 0)
         sum = sum ^ 8'($urandom_range(1, 255));
      broken = (kind >= 12 && kind < 17);
      n_sent = broken ? $urandom_range(0, body.size()) : body.size();
      send_byte(marker);
      send_byte(len);
      for (int j = 0; j < n_sent; j++)
         send_byte(body[j]);
      if (!broken)
         send_byte(sum);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (frames_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == CSR_ADDR_MARKER)
         pp_marker = data[BYTE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_marker();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_MARKER;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("start_marker", {8'h00, pp_marker}, {8'h00, csr_prdata[BYTE_W-1:0]});
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result word receiver with random stalls and one long hold-off
   initial begin : result_drain
      int unsigned n;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            n = pick_gap();
            if (n != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frames_due.size() == 0) begin
            $display("%0t: result word with none expected, actual good=%b id=%h value=%h",
                     $time, rsp_if.frame_good, rsp_if.record_id, rsp_if.record_value);
            errors++;
         end else begin
            want = frames_due.pop_front();
            check_field("frame_good", 16'(want.frame_good), 16'(rsp_if.frame_good));
            check_field("record_id", 16'(want.record_id), 16'(rsp_if.record_id));
            check_field("record_value", want.record_value, rsp_if.record_value);
            check_field("action", 16'(want.action), 16'(rsp_if.action));
            check_field("ack_seen", 16'(want.ack_seen), 16'(rsp_if.ack_seen));
            check_field("ack_total", want.ack_total, rsp_if.ack_total);
            frames_checked++;
            if (want.frame_good)
               frames_good++;
            if (want.action != ACT_NONE)
               actions_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, frames_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] marker;
      int unsigned       budget;
      int unsigned       base_used;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      pp_marker      = START_MARKER_RESET;
      pp_phase       = PH_WAIT;
      pp_len         = '0;
      pp_index       = '0;
      pp_sum         = '0;
      pp_rec         = RP_ID;
      pp_id          = '0;
      pp_left        = '0;
      pp_wide        = 1'b0;
      pp_value       = '0;
      pp_ack         = 1'b0;
      pp_acks        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read_marker();

      for (int i = 0; i < N_ROWS; i++)
         send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
      base_used = bytes_used;

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         case (p)
            0:       marker = 8'h00;
            1:       marker = 8'hFF;
            3:       marker = START_MARKER_RESET;
            default: marker = 8'($urandom);
         endcase
         csr_write(CSR_ADDR_MARKER, {24'($urandom), marker});
         if (p == 2)
            csr_write(CSR_ADDR_SPARE, $urandom);
         csr_read_marker();
         no_idle = (p == 1);
         if (p == 3)
            hold_off_req = 1'b1;
         // overall byte target, with a floor so that no phase is skipped
         budget = base_used + (p + 1) * PHASE_BYTES;
         if (budget < bytes_used + PHASE_BYTES / 2)
            budget = bytes_used + PHASE_BYTES / 2;
         while (bytes_used < budget)
            send_frame(marker);
      end
      no_idle = 1'b0;
      settle();

      $display("Summary: %0d bytes accepted, %0d frames checked, %0d good, %0d actions decoded",
               bytes_accepted, frames_checked, frames_good, actions_seen);
      $display("Summary: markers 0x00, 0xFF, 0xAA and random, %0d long frames, one long stall",
               big_frames);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
